>>> design/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heap sort engine
// Store geometry, index widths, sequencer states and the signed compare.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int DEPTH = 64;
    localparam int DW    = 32;
    localparam int AW    = $clog2(DEPTH);      // store address
    localparam int CW    = $clog2(DEPTH + 1);  // element count, heap size
    localparam int CHW   = AW + 2;             // child index 2*node+2

    typedef logic signed [DW-1:0] value_t;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_BRD   = 12'b0000_0000_0010,
        S_BCAP  = 12'b0000_0000_0100,
        S_SL    = 12'b0000_0000_1000,
        S_SR    = 12'b0000_0001_0000,
        S_SD    = 12'b0000_0010_0000,
        S_W0    = 12'b0000_0100_0000,
        S_W1    = 12'b0000_1000_0000,
        S_W2    = 12'b0001_0000_0000,
        S_ERD   = 12'b0010_0000_0000,
        S_EOUT  = 12'b0100_0000_0000,
        S_EHOLD = 12'b1000_0000_0000
    } state_t;

    function automatic logic signed_less(input logic [DW-1:0] a, input logic [DW-1:0] b);
        signed_less = $signed(a) < $signed(b);
    endfunction

endpackage

>>> design/hse_in_if.sv
// ----------------------------------------------------------------------------
// hse_in_if: element request channel
// One signed value per request, last marks the end of the set.
// ----------------------------------------------------------------------------
interface hse_in_if;

    logic            valid;
    logic            ready;
    hse_pkg::value_t value;
    logic            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

>>> design/hse_out_if.sv
// ----------------------------------------------------------------------------
// hse_out_if: sorted result channel
// One sorted value per request, last_res on the final one of the set.
// ----------------------------------------------------------------------------
interface hse_out_if;

    logic            valid;
    logic            ready;
    hse_pkg::value_t value_res;
    logic            last_res;

    modport source (output valid, output value_res, output last_res, input ready);
    modport sink   (input valid, input value_res, input last_res, output ready);

endinterface

>>> design/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine: max-heap sort of a set of signed 32-bit values
// Loads a set, heapifies it, sorts it in place and streams it out ascending.
// ----------------------------------------------------------------------------
//  channel  | dir | payload               | request when
//  ---------+-----+-----------------------+---------------------------
//  items    | in  | value[31:0], last     | valid && ready
//  sorted   | out | value_res[31:0], last | valid && ready
//
//  Loading accepts one element per cycle; ready is high only while loading.
//  Each sift-down fetches its start value in S_BRD and S_BCAP (S_W0, S_W1
//  and S_W2 for a root swap), then each level steps through S_SL, S_SR and
//  S_SD on the single RAM read port. Each result then passes S_ERD and
//  S_EOUT and waits in S_EHOLD through any stall on sorted. No clearing
//  pass after reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module heap_sort_engine (
    input  logic      clk,
    input  logic      rst_n,
    hse_in_if.sink    items,
    hse_out_if.source sorted
);

    hse_pkg::state_t           state_reg, state_next;
    logic [hse_pkg::CW-1:0]    count_reg, count_next;
    logic [hse_pkg::CW-1:0]    n_reg, n_next;
    logic [hse_pkg::CW-1:0]    i_reg, i_next;
    logic [hse_pkg::CW-1:0]    size_reg, size_next;
    logic [hse_pkg::AW-1:0]    node_reg, node_next;
    logic [hse_pkg::AW-1:0]    k_reg, k_next;
    logic                      build_reg, build_next;
    logic [hse_pkg::DW-1:0]    v_reg, v_next;
    logic [hse_pkg::DW-1:0]    best_reg, best_next;
    logic                      big_l_reg, big_l_next;
    logic                      r_ok_reg, r_ok_next;
    logic                      out_valid_reg, out_valid_next;
    logic [hse_pkg::DW-1:0]    value_res_reg, value_res_next;
    logic                      last_res_reg, last_res_next;

    logic                      we;
    logic [hse_pkg::AW-1:0]    waddr, raddr;
    logic [hse_pkg::DW-1:0]    wdata, rdata;

    logic [hse_pkg::CHW-1:0]   child_l, child_r, size_x;
    logic [hse_pkg::CW-1:0]    n_load;
    logic                      cmp_lt;
    logic                      sift_fin;

    hse_ram #(
        .WIDTH (hse_pkg::DW),
        .DEPTH (hse_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign child_l = {1'b0, node_reg, 1'b1};
    assign child_r = child_l + hse_pkg::CHW'(1);
    assign size_x  = {{(hse_pkg::CHW - hse_pkg::CW){1'b0}}, size_reg};

    // the one comparator: held value vs left child, then best vs right child
    assign cmp_lt = hse_pkg::signed_less((state_reg == hse_pkg::S_SD) ? best_reg : v_reg,
                                         rdata);

    assign n_load = (count_reg < hse_pkg::CW'(hse_pkg::DEPTH))
                  ? count_reg + hse_pkg::CW'(1) : count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        size_next      = size_reg;
        node_next      = node_reg;
        k_next         = k_reg;
        build_next     = build_reg;
        v_next         = v_reg;
        best_next      = best_reg;
        big_l_next     = big_l_reg;
        r_ok_next      = r_ok_reg;
        out_valid_next = out_valid_reg;
        value_res_next = value_res_reg;
        last_res_next  = last_res_reg;
        we             = 1'b0;
        waddr          = node_reg;
        wdata          = v_reg;
        raddr          = node_reg;
        sift_fin       = 1'b0;

        unique case (state_reg)
            hse_pkg::S_IDLE:
            begin
                if (items.valid)
                begin
                    if (count_reg < hse_pkg::CW'(hse_pkg::DEPTH))
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[hse_pkg::AW-1:0];
                        wdata      = items.value;
                        count_next = count_reg + hse_pkg::CW'(1);
                    end
                    if (items.last)
                    begin
                        count_next = '0;
                        n_next     = n_load;
                        size_next  = n_load;
                        k_next     = '0;
                        if (n_load >= hse_pkg::CW'(2))
                        begin
                            build_next = 1'b1;
                            i_next     = n_load >> 1;
                            node_next  = hse_pkg::AW'((n_load >> 1) - hse_pkg::CW'(1));
                            state_next = hse_pkg::S_BRD;
                        end
                        else
                        begin
                            state_next = hse_pkg::S_ERD;
                        end
                    end
                end
            end
            hse_pkg::S_BRD:
            begin
                raddr      = node_reg;
                state_next = hse_pkg::S_BCAP;
            end
            hse_pkg::S_BCAP:
            begin
                v_next     = rdata;
                state_next = hse_pkg::S_SL;
            end
            hse_pkg::S_SL:
            begin
                if (child_l < size_x)
                begin
                    raddr      = child_l[hse_pkg::AW-1:0];
                    state_next = hse_pkg::S_SR;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = node_reg;
                    wdata    = v_reg;
                    sift_fin = 1'b1;
                end
            end
            hse_pkg::S_SR:
            begin
                best_next  = cmp_lt ? rdata : v_reg;
                big_l_next = cmp_lt;
                r_ok_next  = child_r < size_x;
                raddr      = child_r[hse_pkg::AW-1:0];
                state_next = hse_pkg::S_SD;
            end
            hse_pkg::S_SD:
            begin
                we = 1'b1;
                priority if (r_ok_reg && cmp_lt)
                begin
                    wdata      = rdata;
                    node_next  = child_r[hse_pkg::AW-1:0];
                    state_next = hse_pkg::S_SL;
                end
                else if (big_l_reg)
                begin
                    wdata      = best_reg;
                    node_next  = child_l[hse_pkg::AW-1:0];
                    state_next = hse_pkg::S_SL;
                end
                else
                begin
                    wdata    = v_reg;
                    sift_fin = 1'b1;
                end
            end
            hse_pkg::S_W0:
            begin
                raddr      = '0;
                state_next = hse_pkg::S_W1;
            end
            hse_pkg::S_W1:
            begin
                best_next  = rdata;
                raddr      = i_reg[hse_pkg::AW-1:0];
                state_next = hse_pkg::S_W2;
            end
            hse_pkg::S_W2:
            begin
                // old root goes to the tail, tail value sifts from the root
                we         = 1'b1;
                waddr      = i_reg[hse_pkg::AW-1:0];
                wdata      = best_reg;
                v_next     = rdata;
                size_next  = i_reg;
                node_next  = '0;
                state_next = hse_pkg::S_SL;
            end
            hse_pkg::S_ERD:
            begin
                raddr      = k_reg;
                state_next = hse_pkg::S_EOUT;
            end
            hse_pkg::S_EOUT:
            begin
                out_valid_next = 1'b1;
                value_res_next = rdata;
                last_res_next  = (k_reg == hse_pkg::AW'(n_reg - hse_pkg::CW'(1)));
                state_next     = hse_pkg::S_EHOLD;
            end
            hse_pkg::S_EHOLD:
            begin
                if (sorted.ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_res_reg)
                    begin
                        state_next = hse_pkg::S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + hse_pkg::AW'(1);
                        state_next = hse_pkg::S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = hse_pkg::S_IDLE;
            end
        endcase

        // end of one sift-down: next heapify node, next root swap, or output
        if (sift_fin)
        begin
            priority if (build_reg && i_reg != hse_pkg::CW'(1))
            begin
                i_next     = i_reg - hse_pkg::CW'(1);
                node_next  = hse_pkg::AW'(i_reg - hse_pkg::CW'(2));
                state_next = hse_pkg::S_BRD;
            end
            else if (build_reg)
            begin
                build_next = 1'b0;
                i_next     = n_reg - hse_pkg::CW'(1);
                state_next = hse_pkg::S_W0;
            end
            else if (i_reg != hse_pkg::CW'(1))
            begin
                i_next     = i_reg - hse_pkg::CW'(1);
                state_next = hse_pkg::S_W0;
            end
            else
            begin
                k_next     = '0;
                state_next = hse_pkg::S_ERD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hse_pkg::S_IDLE;
            count_reg     <= '0;
            build_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            build_reg     <= build_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        i_reg         <= i_next;
        size_reg      <= size_next;
        node_reg      <= node_next;
        k_reg         <= k_next;
        v_reg         <= v_next;
        best_reg      <= best_next;
        big_l_reg     <= big_l_next;
        r_ok_reg      <= r_ok_next;
        value_res_reg <= value_res_next;
        last_res_reg  <= last_res_next;
    end

    assign items.ready      = (state_reg == hse_pkg::S_IDLE);
    assign sorted.valid     = out_valid_reg;
    assign sorted.value_res = value_res_reg;
    assign sorted.last_res  = last_res_reg;

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !sorted.valid)
        else $error("result pending while loading");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hse_pkg::CW'(hse_pkg::DEPTH))
        else $error("element count beyond depth");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (sorted.valid && sorted.ready && sorted.last_res) |=> items.ready)
        else $error("not ready for a new set after final result");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hse_pkg::S_SL) |-> (size_reg <= n_reg && node_reg < size_reg))
        else $error("sift node outside heap");

endmodule

>>> design/hse_ram.sv
// ----------------------------------------------------------------------------
// hse_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> verif/hse_sort_checker.sv
// ----------------------------------------------------------------------------
// hse_sort_checker: scoreboard for the heap sort engine
// Watches both channels, keeps the open set in ascending order as requests
// arrive, and on the closing request queues the sorted results for
// comparison against the sorted channel.
// ----------------------------------------------------------------------------
module hse_sort_checker (
    input  logic clk,
    input  logic rst_n,
    hse_in_if    items,
    hse_out_if   sorted,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        hse_pkg::value_t value;
        logic            last;
    } sorted_word_t;

    hse_pkg::value_t open_set[$];    // current set, kept in ascending order
    sorted_word_t    sorted_due[$];  // results still to come, oldest first

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic take_element(input hse_pkg::value_t v, input logic fin);
        int pos;
        sorted_word_t word;
        pos = 0;
        // set saturates: elements past DEPTH are dropped, last still closes it
        if (open_set.size() < hse_pkg::DEPTH)
        begin
            while (pos < open_set.size() && open_set[pos] <= v)
                pos++;
            open_set.insert(pos, v);
        end
        if (fin)
        begin
            foreach (open_set[k])
            begin
                word.value = open_set[k];
                word.last  = (k == open_set.size() - 1);
                sorted_due.push_back(word);
            end
            open_set.delete();
        end
    endtask

    task automatic check_result(input hse_pkg::value_t v, input logic fin);
        sorted_word_t want;
        if (sorted_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result value=%0d last=%0b", v, fin));
        end
        else
        begin
            want = sorted_due.pop_front();
            if (v !== want.value)
                report_mismatch($sformatf("value_res got %0d want %0d", v, want.value));
            if (fin !== want.last)
                report_mismatch($sformatf("last_res got %0b want %0b (value %0d)",
                                          fin, want.last, want.value));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_set.delete();
            sorted_due.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (items.valid && items.ready)
                take_element(items.value, items.last);
            if (sorted.valid && sorted.ready)
                check_result(sorted.value_res, sorted.last_res);
            pending <= sorted_due.size();
        end
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: heap sort engine regression
// Sends directed sets (single values, extremes, duplicates, presorted and
// reversed), then random sets of mostly small sizes with a few full and
// overflowing ones. Sender idles in bursts, receiver stalls on its own
// pattern and holds off once for a long stretch. The checker scores results.
// ----------------------------------------------------------------------------
module testbench;

    localparam hse_pkg::value_t VMIN       = hse_pkg::value_t'(32'h8000_0000);
    localparam hse_pkg::value_t VMAX       = hse_pkg::value_t'(32'h7FFF_FFFF);
    localparam int              IDLE_LIMIT = 20000;
    localparam int              HOLD_OFF   = 400;
    localparam int              RAND_ITEMS = 200;

    logic clk = 1'b0;
    logic rst_n;

    hse_in_if  items();
    hse_out_if sorted();

    int              mismatches;
    int              pending;
    int              burst_left = 0;
    int              idle_cycles = 0;
    bit              random_phase = 0;
    hse_pkg::value_t set_buf[$];

    heap_sort_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .sorted (sorted)
    );

    hse_sort_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .sorted     (sorted),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // skewed toward extremes and a narrow band so duplicates are common
    function automatic hse_pkg::value_t pick_value();
        case ($urandom_range(0, 9))
            0:       return VMIN;
            1:       return VMAX;
            2, 3:    return hse_pkg::value_t'(int'($urandom_range(0, 8)) - 4);
            default: return hse_pkg::value_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input hse_pkg::value_t v, input logic fin);
        if (burst_left == 0)
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        items.valid <= 1'b1;
        items.value <= v;
        items.last  <= fin;
        @(posedge clk);
        while (!items.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_buffered_set();
        foreach (set_buf[k])
            send_item(set_buf[k], k == set_buf.size() - 1);
    endtask

    // receiver: stretches of always-ready, light and heavy stall, plus one
    // long hold-off once random traffic is flowing
    initial
    begin
        int stretch_left;
        int mode;
        bit held_off;
        stretch_left = 0;
        mode = 0;
        held_off = 0;
        sorted.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (random_phase && !held_off && sorted.valid)
            begin
                held_off = 1;
                sorted.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    stretch_left = $urandom_range(5, 40);
                end
                stretch_left--;
                case (mode)
                    0:       sorted.ready <= 1'b1;
                    1:       sorted.ready <= ($urandom_range(0, 99) < 70);
                    default: sorted.ready <= ($urandom_range(0, 99) < 20);
                endcase
            end
        end
    end

    // stall watchdog: cycles with no request on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((items.valid && items.ready) || (sorted.valid && sorted.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("heap_sort_engine regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int stored;
        int n;
        int r;
        rst_n       = 1'b0;
        items.valid = 1'b0;
        items.value = '0;
        items.last  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single-element sets at both extremes, then a pair of both
        set_buf = '{VMIN};
        send_buffered_set();
        set_buf = '{VMAX};
        send_buffered_set();
        set_buf = '{VMAX, VMIN};
        send_buffered_set();
        // duplicates, zero, +-1 and extremes mixed
        set_buf = '{hse_pkg::value_t'(0), hse_pkg::value_t'(-1), hse_pkg::value_t'(1),
                    hse_pkg::value_t'(-1), VMAX, VMIN, hse_pkg::value_t'(0)};
        send_buffered_set();
        // already ascending, then descending
        set_buf = '{VMIN, hse_pkg::value_t'(-7), hse_pkg::value_t'(3), VMAX};
        send_buffered_set();
        set_buf = '{VMAX, hse_pkg::value_t'(100), hse_pkg::value_t'(-100), VMIN};
        send_buffered_set();

        random_phase = 1;
        stored = 0;
        while (stored < RAND_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n = $urandom_range(1, 8);
            else if (r < 88)
                n = $urandom_range(9, 32);
            else if (r < 95)
                n = hse_pkg::DEPTH;
            else
                n = $urandom_range(hse_pkg::DEPTH + 1, hse_pkg::DEPTH + 4);  // overflow
            for (int i = 0; i < n; i++)
                send_item(pick_value(), i == n - 1);
            stored += (n < hse_pkg::DEPTH) ? n : hse_pkg::DEPTH;
        end
        items.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (mismatches == 0)
            $display("heap_sort_engine regression: pass");
        else
            $display("heap_sort_engine regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/hse_pkg.sv
design/hse_in_if.sv
design/hse_out_if.sv
design/hse_ram.sv
design/heap_sort_engine.sv
verif/hse_sort_checker.sv
verif/testbench.sv
